// ===== hdl/twg_pkg.sv =====
// shared types, constants and sine table functions for the tick waveform generator
package twg_pkg;

    // apb register map
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_WAVE_MODE    = 3'd0,
        REG_AMPLITUDE    = 3'd1,
        REG_OFFSET       = 3'd2,
        REG_PHASE_STEP   = 3'd3,
        REG_PHASE_OFFSET = 3'd4
    } reg_index_t;

    // waveform kinds, unused codes decode to sawtooth
    typedef enum logic [2:0] {
        MODE_CONST    = 3'd0,
        MODE_SINE     = 3'd1,
        MODE_SQUARE   = 3'd2,
        MODE_TRIANGLE = 3'd3,
        MODE_SAWTOOTH = 3'd4
    } wave_mode_t;

    // configuration registers as seen by the datapath
    typedef struct packed {
        logic [2:0]         wave_mode;
        logic [13:0]        amplitude_mv;
        logic signed [14:0] offset_mv;
        logic [31:0]        phase_step;
        logic [31:0]        phase_offset;
    } cfg_t;

    // shaped phase handed from the phase stages to the scale stages
    typedef struct packed {
        wave_mode_t         kind;
        logic signed [16:0] tri_a;
        logic signed [15:0] saw_s;
    } shape_t;

    localparam logic [12:0] LEVEL_MAX = 13'd5000;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [24:0] TWO_PI_Q20 = 25'sd6588397;
    localparam int SQUARE_UNIT = 32768;

    // denominators of the sine series, (2n)(2n+1)
    localparam logic [63:0] TAYLOR_DIV [9] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

    // round(32767 * sin(pi/2 * r / 2^qbits)), evaluated at elaboration
    function automatic logic signed [15:0] quarter_sine(input int unsigned r,
                                                         input int unsigned qbits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        scaled;
        x = (HALF_PI_Q30 * 64'(r)) >> qbits;
        x2 = (x * x) >> 30;
        term = x;
        sum = $signed(x);
        for (int n = 1; n <= 9; n++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[n - 1];
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end
            else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
        end
        scaled = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        return scaled[15:0];
    endfunction

    // table entry k of a 2^tbits entry full-wave table, mirrored from one quarter
    function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                       input int unsigned tbits);
        int unsigned        qbits;
        int unsigned        q;
        int unsigned        r;
        logic signed [15:0] v;
        qbits = tbits - 2;
        q = k >> qbits;
        r = k & ((32'd1 << qbits) - 32'd1);
        if ((q & 1) != 0) begin
            v = quarter_sine((32'd1 << qbits) - r, qbits);
        end
        else begin
            v = quarter_sine(r, qbits);
        end
        if ((q & 2) != 0) begin
            v = -v;
        end
        return v;
    endfunction

endpackage

// ===== hdl/tick_waveform_generator.sv =====
// throughput: one tick word per cycle, busy stays low, results are never held
// stages: phase multiply, phase add and sine rom read, amplitude multiply,
//   2*pi multiply, rounding, offset add and clamp
// reset: rst_n clears the configuration registers and the valid bits, data registers keep junk
// top level of the tick waveform generator
module tick_waveform_generator #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [31:0]                   tick_number,
    output logic                          done,
    output logic [12:0]                   level_mv,
    output logic                          clamped,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [twg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [twg_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);

    twg_pkg::cfg_t             cfg;

    logic                      s1_valid_reg;
    logic [PHASE_BITS-1:0]     ramp_reg;
    logic [63:0]               ramp_full;
    logic [63:0]               offset_ext;
    logic [PHASE_BITS-1:0]     phase;
    logic [SINE_TABLE_BITS-1:0] rom_addr;
    logic [15:0]               u;
    logic signed [17:0]        u_s;
    logic signed [17:0]        tri_wide;
    twg_pkg::wave_mode_t       kind;
    twg_pkg::shape_t           shape_next;
    twg_pkg::shape_t           shape_reg;
    logic                      s2_valid_reg;
    logic signed [15:0]        sine;

    assign busy = 1'b0;

    // configuration port
    twg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stage 1: ramp = tick * step modulo the phase word
    assign ramp_full = 64'(tick_number) * 64'(cfg.phase_step);

    // stage 2: phase word, table address and triangle fold
    assign offset_ext = 64'(cfg.phase_offset);
    assign phase      = ramp_reg + offset_ext[PHASE_BITS-1:0];
    assign rom_addr   = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign u          = phase[PHASE_BITS-1 -: 16];
    assign u_s        = $signed({2'b00, u});

    always_comb
    begin
        if (u < 16'd16384)
        begin
            tri_wide = u_s;
        end
        else if (u < 16'd49152)
        begin
            tri_wide = 18'sd32768 - u_s;
        end
        else
        begin
            tri_wide = u_s - 18'sd65536;
        end
    end

    // mode decode, unused codes act as sawtooth
    always_comb
    begin
        case (cfg.wave_mode)
            twg_pkg::MODE_CONST:    kind = twg_pkg::MODE_CONST;
            twg_pkg::MODE_SINE:     kind = twg_pkg::MODE_SINE;
            twg_pkg::MODE_SQUARE:   kind = twg_pkg::MODE_SQUARE;
            twg_pkg::MODE_TRIANGLE: kind = twg_pkg::MODE_TRIANGLE;
            default:                kind = twg_pkg::MODE_SAWTOOTH;
        endcase
    end

    always_comb
    begin
        shape_next.kind  = kind;
        shape_next.tri_a = tri_wide[16:0];
        shape_next.saw_s = $signed(ramp_reg[PHASE_BITS-1 -: 16]);
    end

    twg_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (sine)
    );

    // valid bits of the phase stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // data of the phase stages
    always_ff @(posedge clk)
    begin
        ramp_reg  <= ramp_full[PHASE_BITS-1:0];
        shape_reg <= shape_next;
    end

    // scaling, offset and clamp
    twg_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s2_valid_reg),
        .shape    (shape_reg),
        .sine     (sine),
        .done     (done),
        .level_mv (level_mv),
        .clamped  (clamped)
    );

    // every result word traces back to a taken tick word
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result word without a matching tick word");

    // a taken tick word always produces a result word
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ##4 done)
        else $error("tick word lost in scale stages");

    // the phase stages never lose a word
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("tick word lost between phase stages");

endmodule

// ===== hdl/twg_regs.sv =====
// apb configuration registers of the tick waveform generator
module twg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [twg_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [twg_pkg::APB_DATA_W-1:0] pwdata,
    output logic [twg_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output twg_pkg::cfg_t                 cfg
);

    twg_pkg::cfg_t  cfg_reg;
    twg_pkg::cfg_t  cfg_next;
    logic [2:0]     index;
    logic           wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                twg_pkg::REG_WAVE_MODE:    cfg_next.wave_mode    = pwdata[2:0];
                twg_pkg::REG_AMPLITUDE:    cfg_next.amplitude_mv = pwdata[13:0];
                twg_pkg::REG_OFFSET:       cfg_next.offset_mv    = $signed(pwdata[14:0]);
                twg_pkg::REG_PHASE_STEP:   cfg_next.phase_step   = pwdata;
                twg_pkg::REG_PHASE_OFFSET: cfg_next.phase_offset = pwdata;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb
    begin
        case (index)
            twg_pkg::REG_WAVE_MODE:    prdata = 32'(cfg_reg.wave_mode);
            twg_pkg::REG_AMPLITUDE:    prdata = 32'(cfg_reg.amplitude_mv);
            twg_pkg::REG_OFFSET:       prdata = 32'(cfg_reg.offset_mv);
            twg_pkg::REG_PHASE_STEP:   prdata = cfg_reg.phase_step;
            twg_pkg::REG_PHASE_OFFSET: prdata = cfg_reg.phase_offset;
            default:                   prdata = '0;
        endcase
    end

endmodule

// ===== hdl/twg_sine_rom.sv =====
// sine lookup rom, q1.15 entries, registered read
module twg_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                    clk,
    input  logic [TABLE_BITS-1:0]   addr,
    output logic signed [15:0]      rd_data
);

    localparam int TABLE_SIZE = 1 << TABLE_BITS;

    logic signed [15:0] rom_mem [TABLE_SIZE];
    logic signed [15:0] rd_data_reg;

    // table contents fixed at elaboration
    for (genvar k = 0; k < TABLE_SIZE; k++)
    begin : g_rom
        assign rom_mem[k] = twg_pkg::sine_entry(k, TABLE_BITS);
    end

    // synchronous read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= rom_mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/twg_scale.sv =====
// amplitude scaling, rounding, offset and clamp stages
module twg_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  twg_pkg::cfg_t      cfg,
    input  logic               in_valid,
    input  twg_pkg::shape_t    shape,
    input  logic signed [15:0] sine,
    output logic               done,
    output logic [12:0]        level_mv,
    output logic               clamped
);

    localparam logic signed [55:0] ROUND_HALF = 56'sd1 <<< 35;

    logic               mul_valid_reg;
    logic               wide_valid_reg;
    logic               wave_valid_reg;
    logic               done_reg;

    logic signed [16:0] operand;
    logic signed [14:0] amp_s;
    logic signed [31:0] prod_next;
    logic signed [31:0] prod_reg;
    logic               tri_reg;
    logic signed [55:0] wide_next;
    logic signed [55:0] wide_reg;
    logic signed [55:0] rounded;
    logic signed [16:0] wave_reg;
    logic signed [17:0] raw;
    logic [12:0]        level_next;
    logic               clamped_next;
    logic [12:0]        level_mv_reg;
    logic               clamped_reg;

    // operand per waveform, square uses a full-scale q15 unit
    always_comb
    begin
        case (shape.kind)
            twg_pkg::MODE_CONST:    operand = '0;
            twg_pkg::MODE_SINE:     operand = 17'(sine);
            twg_pkg::MODE_SQUARE:
            begin
                if (sine > 16'sd0)
                begin
                    operand = 17'(twg_pkg::SQUARE_UNIT);
                end
                else if (sine == 16'sd0)
                begin
                    operand = '0;
                end
                else
                begin
                    operand = -17'(twg_pkg::SQUARE_UNIT);
                end
            end
            twg_pkg::MODE_TRIANGLE: operand = shape.tri_a;
            default:                operand = 17'(shape.saw_s);
        endcase
    end

    assign amp_s     = $signed({1'b0, cfg.amplitude_mv});
    assign prod_next = 32'(amp_s) * 32'(operand);

    // triangle takes the 2*pi scale, the rest are aligned to the same binary point
    always_comb
    begin
        if (tri_reg)
        begin
            wide_next = 56'(prod_reg) * 56'(twg_pkg::TWO_PI_Q20);
        end
        else
        begin
            wide_next = 56'(prod_reg) <<< 21;
        end
    end

    // round half up and drop 36 fraction bits
    assign rounded = wide_reg + ROUND_HALF;

    // offset and clamp
    always_comb
    begin
        raw = 18'(wave_reg) + 18'(cfg.offset_mv);
        if (raw < 18'sd0)
        begin
            level_next   = '0;
            clamped_next = 1'b1;
        end
        else if (raw > $signed({5'd0, twg_pkg::LEVEL_MAX}))
        begin
            level_next   = twg_pkg::LEVEL_MAX;
            clamped_next = 1'b1;
        end
        else
        begin
            level_next   = raw[12:0];
            clamped_next = 1'b0;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg  <= 1'b0;
            wide_valid_reg <= 1'b0;
            wave_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            mul_valid_reg  <= in_valid;
            wide_valid_reg <= mul_valid_reg;
            wave_valid_reg <= wide_valid_reg;
            done_reg       <= wave_valid_reg;
        end
    end

    // stage data
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        tri_reg      <= (shape.kind == twg_pkg::MODE_TRIANGLE);
        wide_reg     <= wide_next;
        wave_reg     <= rounded[52:36];
        level_mv_reg <= level_next;
        clamped_reg  <= clamped_next;
    end

    assign done     = done_reg;
    assign level_mv = level_mv_reg;
    assign clamped  = clamped_reg;

    // a result word never lies past the clamp range
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> level_mv_reg <= twg_pkg::LEVEL_MAX)
        else $error("level above clamp limit");

    // a clamped word sits on one of the two rails
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && clamped_reg |-> level_mv_reg == '0 || level_mv_reg == twg_pkg::LEVEL_MAX)
        else $error("clamped level off the rails");

endmodule
